// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dlrf_pkg.sv
// Shared constants, codes and state type of the drop light relief filter.
// No dependencies; used by the top level and the checker.
`default_nettype none

package dlrf_pkg;

  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned EffW     = ColW + 1;
  localparam int unsigned PendW    = EffW + 1;
  localparam int unsigned RowW     = 16;
  localparam int unsigned RamAw    = ColW + 2;
  localparam int unsigned RamDepth = 2 ** RamAw;
  localparam int unsigned PixW     = 32;
  localparam int unsigned WinN     = 9;
  localparam int unsigned WinIdxW  = $clog2(WinN);
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegMode   = 3'd2,
    RegLightX = 3'd3,
    RegLightY = 3'd4,
    RegDepth  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ModeGray = 2'd0,
    ModeRgb  = 2'd1,
    ModeRgba = 2'd2
  } pix_mode_e;

  typedef enum logic {
    KindPixel = 1'b0,
    KindFlush = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StGrad,
    StNx,
    StNy,
    StSx,
    StSy,
    StMag,
    StSq,
    StTsq,
    StTprod,
    StCmp,
    StAcc,
    StOut
  } state_e;

endpackage

`default_nettype wire

// File: hdl/dlrf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module dlrf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/drop_light_relief_filter_unit.sv
// Drop light relief filter top level: line memory, window, lighting sequencer.
// Depends on dlrf_pkg and dlrf_ram.
`default_nettype none

// Pixels enter in raster order; the result for pixel k leaves after pixel k+W+1 has been
// accepted, and the last W+1 results of a frame are drained with flush requests. A request
// that yields no result leaves the block idle and ready. A request that yields a result holds
// off new requests until the result is loaded for output: nine single-port reads of the line
// memory fill the window, then, per colour channel, one shared multiplier forms the gradient
// products and a bit-serial search of nine steps, each through the Tsq, Tprod and Cmp states,
// finds the lighting term; a flat neighbourhood skips both. The line memory needs no clearing
// pass after reset.
module drop_light_relief_filter_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dlrf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [dlrf_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // chan0 [7:0], chan1 [15:8], chan2 [23:16], alpha_in [31:24]
  input  wire logic [31:0]                  s_axis_tdata,
  // kind
  input  wire logic                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // out_chan0 [7:0], out_chan1 [15:8], out_chan2 [23:16], alpha_out [31:24]
  output logic [31:0]                       m_axis_tdata,
  // row_end
  output logic                              m_axis_tlast,
  // frame_end
  output logic                              m_axis_tuser
);

  localparam int unsigned ColW    = dlrf_pkg::ColW;
  localparam int unsigned EffW    = dlrf_pkg::EffW;
  localparam int unsigned PendW   = dlrf_pkg::PendW;
  localparam int unsigned RowW    = dlrf_pkg::RowW;
  localparam int unsigned RamAw   = dlrf_pkg::RamAw;
  localparam int unsigned PixW    = dlrf_pkg::PixW;
  localparam int unsigned WinIdxW = dlrf_pkg::WinIdxW;

  function automatic logic [7:0] chan_of(logic [PixW-1:0] px, logic [1:0] ch);
    chan_of = px[{ch, 3'b000} +: 8];
  endfunction

  function automatic logic [1:0] inc3(logic [1:0] m);
    inc3 = (m == 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(logic [1:0] m);
    dec3 = (m == 2'd0) ? 2'd2 : m - 2'd1;
  endfunction

  dlrf_pkg::state_e state_q, state_d;

  logic [11:0]        width_q;
  logic [15:0]        height_q;
  logic [1:0]         mode_q;
  logic signed [16:0] lx_q, ly_q;
  logic [31:0]        depth_q;

  logic [EffW-1:0] eff_w;
  logic [RowW-1:0] eff_h;

  logic [ColW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [1:0]       in_rm_q, in_rm_d, out_rm_q, out_rm_d;
  logic [PendW-1:0] pend_q, pend_d;

  logic in_acc, frame_done, emit_go, out_load;
  logic [ColW-1:0] wr_col;
  logic [1:0]      wr_rm;

  logic             rd_en, rd_vld_q, iss_done_q;
  logic [1:0]       ri_q, rj_q;
  logic [WinIdxW-1:0] cap_q;
  logic [1:0]       rd_rm;
  logic [ColW-1:0]  rd_col;
  logic [PixW-1:0]  rdata;
  logic [PixW-1:0]  win_q [dlrf_pkg::WinN];

  logic [1:0]         ch_q;
  logic signed [10:0] dx_c, dy_c, dx_q, dy_q;
  logic signed [10:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [27:0] mul_c;
  logic [28:0]        n_q, neg_n;
  logic [32:0]        s_q;
  logic [20:0]        sq_sum;
  logic [27:0]        mag_q;
  logic [55:0]        mag2_q;
  logic [8:0]         q_q, t_c;
  logic [3:0]         bit_q;
  logic [17:0]        tsq_q;
  logic [50:0]        prod_q;
  logic [7:0]         res_q [3];
  logic [10:0]        term_c, v_c;
  logic [7:0]         lit_c;
  logic               last_ch;

  logic m_valid_q, m_last_q, m_user_q;
  logic [31:0] m_data_q;

  always_comb begin
    if (width_q < 12'd3) begin
      eff_w = EffW'(3);
    end else if (int'(width_q) > dlrf_pkg::MaxWidth) begin
      eff_w = EffW'(dlrf_pkg::MaxWidth);
    end else begin
      eff_w = EffW'(width_q);
    end
    eff_h = (height_q < 16'd3) ? 16'd3 : height_q;
  end

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign frame_done = in_row_q >= eff_h;
  assign out_load   = (state_q == dlrf_pkg::StOut) && (!m_valid_q || m_axis_tready);
  assign wr_col     = frame_done ? '0 : in_col_q;
  assign wr_rm      = frame_done ? 2'd0 : in_rm_q;

  always_comb begin
    logic [EffW-1:0]  col_nx;
    logic [RowW-1:0]  wr_row;
    logic [PendW-1:0] pend_nx;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_rm_d   = in_rm_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    out_rm_d  = out_rm_q;
    pend_d    = pend_q;
    emit_go   = 1'b0;
    wr_row    = frame_done ? '0 : in_row_q;
    col_nx    = '0;
    pend_nx   = '0;
    if (in_acc) begin
      if (s_axis_tuser == dlrf_pkg::KindPixel) begin
        if (frame_done) begin
          out_col_d = '0;
          out_row_d = '0;
          out_rm_d  = 2'd0;
        end
        col_nx = EffW'(wr_col) + EffW'(1);
        if (col_nx >= eff_w) begin
          in_col_d = '0;
          in_row_d = wr_row + RowW'(1);
          in_rm_d  = inc3(wr_rm);
        end else begin
          in_col_d = col_nx[ColW-1:0];
          in_row_d = wr_row;
          in_rm_d  = wr_rm;
        end
        pend_nx = (frame_done ? '0 : pend_q) + PendW'(1);
        if (pend_nx >= PendW'(eff_w) + PendW'(2)) begin
          emit_go = 1'b1;
          pend_d  = pend_nx - PendW'(1);
        end else begin
          pend_d  = pend_nx;
        end
      end else if (frame_done && (out_row_q < eff_h)) begin
        emit_go = 1'b1;
        pend_d  = pend_q - PendW'(1);
      end
    end
    if (out_load) begin
      col_nx = EffW'(out_col_q) + EffW'(1);
      if (col_nx >= eff_w) begin
        out_col_d = '0;
        out_row_d = out_row_q + RowW'(1);
        out_rm_d  = inc3(out_rm_q);
        if ({1'b0, out_row_q} + 17'd1 >= {1'b0, eff_h}) begin
          in_col_d  = '0;
          in_row_d  = '0;
          in_rm_d   = 2'd0;
          out_row_d = '0;
          out_rm_d  = 2'd0;
          pend_d    = '0;
        end
      end else begin
        out_col_d = col_nx[ColW-1:0];
      end
    end
    if (cfg_we_i && (cfg_index_i == dlrf_pkg::RegWidth || cfg_index_i == dlrf_pkg::RegHeight))
    begin
      in_col_d  = '0;
      in_row_d  = '0;
      in_rm_d   = 2'd0;
      out_col_d = '0;
      out_row_d = '0;
      out_rm_d  = 2'd0;
      pend_d    = '0;
    end
  end

  always_comb begin
    unique case (ri_q)
      2'd0:    rd_rm = (out_row_q != '0) ? dec3(out_rm_q) : out_rm_q;
      2'd1:    rd_rm = out_rm_q;
      default: rd_rm = ({1'b0, out_row_q} + 17'd1 < {1'b0, eff_h}) ? inc3(out_rm_q) : out_rm_q;
    endcase
    unique case (rj_q)
      2'd0:    rd_col = (out_col_q != '0) ? out_col_q - ColW'(1) : out_col_q;
      2'd1:    rd_col = out_col_q;
      default: rd_col = (EffW'(out_col_q) + EffW'(1) < eff_w) ? out_col_q + ColW'(1) : out_col_q;
    endcase
  end

  dlrf_ram #(
    .Width (PixW),
    .Depth (dlrf_pkg::RamDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (s_axis_tuser == dlrf_pkg::KindPixel)),
    .waddr_i ({wr_rm, wr_col}),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_en),
    .raddr_i (RamAw'({rd_rm, rd_col})),
    .rdata_o (rdata)
  );

  always_comb begin
    dx_c = '0;
    dy_c = '0;
    for (int k = 0; k < 3; k++) begin
      dx_c = dx_c + 11'(chan_of(win_q[3*k], ch_q)) - 11'(chan_of(win_q[3*k+2], ch_q));
      dy_c = dy_c + 11'(chan_of(win_q[6+k], ch_q)) - 11'(chan_of(win_q[k], ch_q));
    end
  end

  always_comb begin
    mul_a = dx_q;
    mul_b = {{6{dx_q[10]}}, dx_q};
    unique case (state_q)
      dlrf_pkg::StNx: mul_b = lx_q;
      dlrf_pkg::StNy: begin
        mul_a = dy_q;
        mul_b = ly_q;
      end
      dlrf_pkg::StSy: begin
        mul_a = dy_q;
        mul_b = {{6{dy_q[10]}}, dy_q};
      end
      default: mul_b = {{6{dx_q[10]}}, dx_q};
    endcase
  end

  assign mul_c   = mul_a * mul_b;
  assign neg_n   = 29'd0 - n_q;
  assign sq_sum  = s_q[20:0] + mul_c[20:0];
  assign t_c     = q_q | (9'd1 << bit_q);
  assign term_c  = n_q[28] ? (11'd0 - {2'b00, q_q}) : {2'b00, q_q};
  assign v_c     = {3'b000, chan_of(win_q[4], ch_q)} + term_c;
  assign lit_c   = v_c[10] ? 8'd0 : ((v_c[9:8] != 2'b00) ? 8'hFF : v_c[7:0]);
  assign last_ch = (mode_q == dlrf_pkg::ModeGray) || (ch_q == 2'd2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlrf_pkg::StIdle:  if (in_acc && emit_go) state_d = dlrf_pkg::StRead;
      dlrf_pkg::StRead: begin
        if (rd_vld_q && cap_q == WinIdxW'(dlrf_pkg::WinN - 1)) state_d = dlrf_pkg::StGrad;
      end
      dlrf_pkg::StGrad: begin
        state_d = (dx_c == '0 && dy_c == '0) ? dlrf_pkg::StAcc : dlrf_pkg::StNx;
      end
      dlrf_pkg::StNx:    state_d = dlrf_pkg::StNy;
      dlrf_pkg::StNy:    state_d = dlrf_pkg::StSx;
      dlrf_pkg::StSx:    state_d = dlrf_pkg::StSy;
      dlrf_pkg::StSy:    state_d = dlrf_pkg::StMag;
      dlrf_pkg::StMag:   state_d = dlrf_pkg::StSq;
      dlrf_pkg::StSq:    state_d = dlrf_pkg::StTsq;
      dlrf_pkg::StTsq:   state_d = dlrf_pkg::StTprod;
      dlrf_pkg::StTprod: state_d = dlrf_pkg::StCmp;
      dlrf_pkg::StCmp:   state_d = (bit_q == 4'd0) ? dlrf_pkg::StAcc : dlrf_pkg::StTsq;
      dlrf_pkg::StAcc:   state_d = last_ch ? dlrf_pkg::StOut : dlrf_pkg::StGrad;
      dlrf_pkg::StOut:   if (out_load) state_d = dlrf_pkg::StIdle;
      default:           state_d = dlrf_pkg::StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == dlrf_pkg::StIdle);
    rd_en         = (state_q == dlrf_pkg::StRead) && !iss_done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dlrf_pkg::StIdle;
      width_q    <= 12'd640;
      height_q   <= 16'd480;
      mode_q     <= dlrf_pkg::ModeGray;
      lx_q       <= '0;
      ly_q       <= '0;
      depth_q    <= 32'd16646400;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_rm_q    <= 2'd0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_rm_q   <= 2'd0;
      pend_q     <= '0;
      rd_vld_q   <= 1'b0;
      iss_done_q <= 1'b0;
      ri_q       <= 2'd0;
      rj_q       <= 2'd0;
      cap_q      <= '0;
      ch_q       <= 2'd0;
      bit_q      <= 4'd0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_rm_q   <= in_rm_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      out_rm_q  <= out_rm_d;
      pend_q    <= pend_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          dlrf_pkg::RegWidth:  width_q  <= cfg_data_i[11:0];
          dlrf_pkg::RegHeight: height_q <= cfg_data_i[15:0];
          dlrf_pkg::RegMode:   mode_q   <= cfg_data_i[1:0];
          dlrf_pkg::RegLightX: lx_q     <= cfg_data_i[16:0];
          dlrf_pkg::RegLightY: ly_q     <= cfg_data_i[16:0];
          dlrf_pkg::RegDepth:  depth_q  <= cfg_data_i;
          default: ;
        endcase
      end
      rd_vld_q <= rd_en;
      if (state_q == dlrf_pkg::StIdle) begin
        iss_done_q <= 1'b0;
        ri_q       <= 2'd0;
        rj_q       <= 2'd0;
        cap_q      <= '0;
        ch_q       <= 2'd0;
      end
      if (rd_en) begin
        if (rj_q == 2'd2) begin
          rj_q <= 2'd0;
          ri_q <= ri_q + 2'd1;
          if (ri_q == 2'd2) iss_done_q <= 1'b1;
        end else begin
          rj_q <= rj_q + 2'd1;
        end
      end
      if (rd_vld_q) cap_q <= cap_q + WinIdxW'(1);
      if (state_q == dlrf_pkg::StSq) bit_q <= 4'd8;
      if (state_q == dlrf_pkg::StCmp && bit_q != 4'd0) bit_q <= bit_q - 4'd1;
      if (state_q == dlrf_pkg::StAcc && !last_ch) ch_q <= ch_q + 2'd1;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) win_q[cap_q] <= rdata;
    unique case (state_q)
      dlrf_pkg::StGrad: begin
        dx_q <= dx_c;
        dy_q <= dy_c;
        q_q  <= '0;
      end
      dlrf_pkg::StNx:    n_q    <= {mul_c[27], mul_c};
      dlrf_pkg::StNy:    n_q    <= n_q + {mul_c[27], mul_c};
      dlrf_pkg::StSx:    s_q    <= {12'd0, mul_c[20:0]};
      dlrf_pkg::StSy:    s_q    <= {4'd0, sq_sum, 8'd0} + {1'b0, depth_q};
      dlrf_pkg::StMag:   mag_q  <= n_q[28] ? neg_n[27:0] : n_q[27:0];
      dlrf_pkg::StSq:    mag2_q <= mag_q * mag_q;
      dlrf_pkg::StTsq:   tsq_q  <= t_c * t_c;
      dlrf_pkg::StTprod: prod_q <= tsq_q * s_q;
      dlrf_pkg::StCmp: begin
        if ({prod_q, 8'd0} <= {3'd0, mag2_q}) q_q <= t_c;
      end
      dlrf_pkg::StAcc:   res_q[ch_q] <= lit_c;
      default: ;
    endcase
    if (out_load) begin
      m_data_q[7:0]   <= res_q[0];
      m_data_q[15:8]  <= (mode_q == dlrf_pkg::ModeGray) ? 8'd0 : res_q[1];
      m_data_q[23:16] <= (mode_q == dlrf_pkg::ModeGray) ? 8'd0 : res_q[2];
      m_data_q[31:24] <= (mode_q == dlrf_pkg::ModeGray || mode_q == dlrf_pkg::ModeRgb) ?
                         8'd0 : win_q[4][31:24];
      m_last_q <= (EffW'(out_col_q) + EffW'(1) == eff_w);
      m_user_q <= (EffW'(out_col_q) + EffW'(1) == eff_w) &&
                  ({1'b0, out_row_q} + 17'd1 == {1'b0, eff_h});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// File: hdl/dlrf_checker.sv
// Port-level checker for the drop light relief filter, bound to its top level.
// Depends on dlrf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dlrf_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [dlrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input wire logic [dlrf_pkg::CfgDataW-1:0] cfg_data_i,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [31:0]                   m_axis_tdata,
  input wire logic                          m_axis_tlast,
  input wire logic                          m_axis_tuser
);

  logic [1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dlrf_pkg::ModeGray;
    end else if (cfg_we_i && cfg_index_i == dlrf_pkg::RegMode) begin
      mode_q <= cfg_data_i[1:0];
    end
  end

  `ASSERT_IMPLIES(frame_end_on_row_end, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
                  "frame end without row end")
  `ASSERT_IMPLIES(gray_upper_zero, m_axis_tvalid && mode_q == dlrf_pkg::ModeGray,
                  m_axis_tdata[31:8] == 24'd0, "grayscale result has nonzero upper bytes")
  `ASSERT_IMPLIES(rgb_alpha_zero, m_axis_tvalid && mode_q == dlrf_pkg::ModeRgb,
                  m_axis_tdata[31:24] == 8'd0, "alpha nonzero outside RGBA mode")
  `ASSERT_NEXT(result_holds, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
               "stalled result changed")

endmodule

bind drop_light_relief_filter_unit dlrf_checker u_dlrf_checker (.*);

`default_nettype wire
